// ===== hw/rtl/hlc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hlc_pkg
// Types, widths and helper functions shared by the homogeneous line clipper.
// ----------------------------------------------------------------------------
package hlc_pkg;

	// coordinate and internal widths
	localparam int CW         = 32;          // coordinate field width
	localparam int BW         = CW + 1;      // boundary value / difference width
	localparam int DW         = CW + 2;      // divider numerator / denominator width
	localparam int TB         = 32;          // fraction bits of t
	localparam int TW         = TB + 1;      // t width, 1.0 included
	localparam int DIV_BPS    = 2;           // quotient bits per divider stage
	localparam int DIV_STAGES = TB / DIV_BPS;
	localparam int PW         = BW + TB;     // product width
	localparam int RW         = BW + 2;      // interpolated result width before saturation
	localparam int NPLANE     = 6;
	localparam int NCOMP      = 4;

	localparam logic [TW-1:0] T_ONE  = {1'b1, {TB{1'b0}}};
	localparam logic [PW-1:0] T_HALF = PW'(1) << (TB - 1);

	typedef logic [NCOMP-1:0][CW-1:0] coord4_t;   // index 0..3 = x, y, z, w

	// input item
	typedef struct packed {
		logic signed [CW-1:0] start_x;
		logic signed [CW-1:0] start_y;
		logic signed [CW-1:0] start_z;
		logic signed [CW-1:0] start_w;
		logic signed [CW-1:0] end_x;
		logic signed [CW-1:0] end_y;
		logic signed [CW-1:0] end_z;
		logic signed [CW-1:0] end_w;
	} clip_in_t;

	// result item
	typedef struct packed {
		logic                 visible;
		logic signed [CW-1:0] clip_start_x;
		logic signed [CW-1:0] clip_start_y;
		logic signed [CW-1:0] clip_start_z;
		logic signed [CW-1:0] clip_start_w;
		logic signed [CW-1:0] clip_end_x;
		logic signed [CW-1:0] clip_end_y;
		logic signed [CW-1:0] clip_end_z;
		logic signed [CW-1:0] clip_end_w;
	} clip_out_t;

	// end points and outcodes that travel beside the divider
	typedef struct packed {
		coord4_t           pa;
		coord4_t           pb;
		logic [NPLANE-1:0] ca;
		logic [NPLANE-1:0] cb;
	} side_t;

	// one plane's divider lane
	typedef struct packed {
		logic          leave;
		logic          enter;
		logic          one;    // ratio saturates at 1.0
		logic [DW-1:0] rem;
		logic [DW-1:0] den;
		logic [TB-1:0] quo;
	} lane_t;

	// parameter selection result
	typedef struct packed {
		logic          visible;
		logic [TW-1:0] tin;
		logic [TW-1:0] tout;
	} sel_t;

	// one restoring division step
	function automatic lane_t div_step(input lane_t l);
		lane_t         n;
		logic [DW:0]   r2;
		n  = l;
		r2 = {l.rem, 1'b0};
		if (r2 >= {1'b0, l.den}) begin
			r2    = r2 - {1'b0, l.den};
			n.quo = {l.quo[TB-2:0], 1'b1};
		end else begin
			n.quo = {l.quo[TB-2:0], 1'b0};
		end
		n.rem = r2[DW-1:0];
		return n;
	endfunction

	// the steps of one divider stage
	function automatic lane_t div_stage(input lane_t l);
		lane_t n;
		n = l;
		for (int i = 0; i < DIV_BPS; i++) begin
			n = div_step(n);
		end
		return n;
	endfunction

	// clamp to the signed coordinate range
	function automatic logic [CW-1:0] sat(input logic signed [RW-1:0] v);
		logic signed [RW-1:0] hi;
		logic signed [RW-1:0] lo;
		hi = {{(RW-CW+1){1'b0}}, {(CW-1){1'b1}}};
		lo = ~hi;
		if (v > hi) begin
			return hi[CW-1:0];
		end else if (v < lo) begin
			return lo[CW-1:0];
		end
		return v[CW-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hlc_setup.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hlc_setup
// Boundary values, outcodes and divider operands (two stages).
// ----------------------------------------------------------------------------
module hlc_setup
	import hlc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire clip_in_t in_item,
	output logic          out_valid,
	output side_t         out_side,
	output lane_t         out_lanes [NPLANE]
);

	coord4_t pa_c, pb_c;
	logic signed [BW-1:0] ba [NPLANE];
	logic signed [BW-1:0] bb [NPLANE];

	logic                 valid_s1;
	coord4_t              pa_s1, pb_s1;
	logic signed [BW-1:0] ba_s1 [NPLANE];
	logic signed [BW-1:0] bb_s1 [NPLANE];

	logic                 valid_s2;
	side_t                side_s2;
	lane_t                lane_s2 [NPLANE];

	side_t                side_d;
	lane_t                lane_d [NPLANE];

	assign pa_c = {in_item.start_w, in_item.start_z, in_item.start_y, in_item.start_x};
	assign pb_c = {in_item.end_w, in_item.end_z, in_item.end_y, in_item.end_x};

	// w+x, w-x, w+y, w-y, w+z, w-z
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ba[2*i]   = $signed({pa_c[3][CW-1], pa_c[3]}) + $signed({pa_c[i][CW-1], pa_c[i]});
			ba[2*i+1] = $signed({pa_c[3][CW-1], pa_c[3]}) - $signed({pa_c[i][CW-1], pa_c[i]});
			bb[2*i]   = $signed({pb_c[3][CW-1], pb_c[3]}) + $signed({pb_c[i][CW-1], pb_c[i]});
			bb[2*i+1] = $signed({pb_c[3][CW-1], pb_c[3]}) - $signed({pb_c[i][CW-1], pb_c[i]});
		end
	end

	// outcodes and crossing operands
	always_comb begin
		logic signed [DW-1:0] ae, be, num, den;
		side_d.pa = pa_s1;
		side_d.pb = pb_s1;
		for (int k = 0; k < NPLANE; k++) begin
			ae = {ba_s1[k][BW-1], ba_s1[k]};
			be = {bb_s1[k][BW-1], bb_s1[k]};
			side_d.ca[k] = ba_s1[k][BW-1] || (ba_s1[k] == '0);
			side_d.cb[k] = bb_s1[k][BW-1] || (bb_s1[k] == '0);
			lane_d[k].leave = bb_s1[k][BW-1];
			lane_d[k].enter = !bb_s1[k][BW-1] && ba_s1[k][BW-1];
			num = bb_s1[k][BW-1] ? ae : -ae;
			den = bb_s1[k][BW-1] ? (ae - be) : (be - ae);
			lane_d[k].rem = num;
			lane_d[k].den = den;
			lane_d[k].one = num >= den;
			lane_d[k].quo = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		pa_s1   <= pa_c;
		pb_s1   <= pb_c;
		ba_s1   <= ba;
		bb_s1   <= bb;
		side_s2 <= side_d;
		lane_s2 <= lane_d;
	end

	assign out_valid = valid_s2;
	assign out_side  = side_s2;
	assign out_lanes = lane_s2;

endmodule

`default_nettype wire

// ===== hw/rtl/hlc_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hlc_div
// Pipelined restoring dividers, one lane per clip plane, DIV_BPS bits a stage.
// ----------------------------------------------------------------------------
module hlc_div
	import hlc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	input  wire side_t in_side,
	input  wire lane_t in_lanes [NPLANE],
	output logic       out_valid,
	output side_t      out_side,
	output lane_t      out_lanes [NPLANE]
);

	logic [DIV_STAGES-1:0] valid_s;
	side_t                 side_s [DIV_STAGES];
	lane_t                 lane_s [DIV_STAGES][NPLANE];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			valid_s <= {valid_s[DIV_STAGES-2:0], in_valid};
		end
	end

	// quotient stages
	always_ff @(posedge clk) begin
		side_s[0] <= in_side;
		for (int k = 0; k < NPLANE; k++) begin
			lane_s[0][k] <= div_stage(in_lanes[k]);
		end
		for (int g = 1; g < DIV_STAGES; g++) begin
			side_s[g] <= side_s[g-1];
			for (int k = 0; k < NPLANE; k++) begin
				lane_s[g][k] <= div_stage(lane_s[g-1][k]);
			end
		end
	end

	assign out_valid = valid_s[DIV_STAGES-1];
	assign out_side  = side_s[DIV_STAGES-1];
	assign out_lanes = lane_s[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== hw/rtl/hlc_select.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hlc_select
// Entry/exit parameter reduction and visibility decision (two stages).
// ----------------------------------------------------------------------------
module hlc_select
	import hlc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	input  wire side_t in_side,
	input  wire lane_t in_lanes [NPLANE],
	output logic       out_valid,
	output side_t      out_side,
	output sel_t       out_sel
);

	logic [TW-1:0] tin_d  [2];
	logic [TW-1:0] tout_d [2];

	logic          valid_s1;
	side_t         side_s1;
	logic [TW-1:0] tin_s1  [2];
	logic [TW-1:0] tout_s1 [2];

	logic          valid_s2;
	side_t         side_s2;
	sel_t          sel_s2;
	sel_t          sel_d;

	// per-half max of entering t, min of leaving t
	always_comb begin
		logic [TW-1:0] t;
		for (int g = 0; g < 2; g++) begin
			tin_d[g]  = '0;
			tout_d[g] = T_ONE;
			for (int j = 0; j < 3; j++) begin
				t = in_lanes[3*g+j].one ? T_ONE : {1'b0, in_lanes[3*g+j].quo};
				if (in_lanes[3*g+j].leave && (t < tout_d[g])) begin
					tout_d[g] = t;
				end
				if (in_lanes[3*g+j].enter && (t > tin_d[g])) begin
					tin_d[g] = t;
				end
			end
		end
	end

	// combine halves and decide
	always_comb begin
		sel_d.tin  = (tin_s1[0] > tin_s1[1]) ? tin_s1[0] : tin_s1[1];
		sel_d.tout = (tout_s1[0] < tout_s1[1]) ? tout_s1[0] : tout_s1[1];
		if ((side_s1.ca | side_s1.cb) == '0) begin
			sel_d.visible = 1'b1;
		end else begin
			sel_d.visible = ((side_s1.ca & side_s1.cb) == '0) && !(sel_d.tin > sel_d.tout);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s1 <= in_side;
		tin_s1  <= tin_d;
		tout_s1 <= tout_d;
		side_s2 <= side_s1;
		sel_s2  <= sel_d;
	end

	assign out_valid = valid_s2;
	assign out_side  = side_s2;
	assign out_sel   = sel_s2;

endmodule

`default_nettype wire

// ===== hw/rtl/hlc_interp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hlc_interp
// Moves outside end points along the segment, saturates, forms the result.
// ----------------------------------------------------------------------------
module hlc_interp
	import hlc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	input  wire side_t in_side,
	input  wire sel_t  in_sel,
	output logic       out_valid,
	output clip_out_t  out_result
);

	logic [BW-1:0]        mag_d [NCOMP];
	logic [NCOMP-1:0]     neg_d;

	logic                 valid_s1;
	side_t                side_s1;
	sel_t                 sel_s1;
	logic [BW-1:0]        mag_s1 [NCOMP];
	logic [NCOMP-1:0]     neg_s1;

	logic                 valid_s2;
	side_t                side_s2;
	sel_t                 sel_s2;
	logic [NCOMP-1:0]     neg_s2;
	logic [PW-1:0]        prs_s2 [NCOMP];
	logic [PW-1:0]        pre_s2 [NCOMP];

	logic signed [RW-1:0] vs_d [NCOMP];
	logic signed [RW-1:0] ve_d [NCOMP];
	logic                 valid_s3;
	logic                 vis_s3;
	logic signed [RW-1:0] vs_s3 [NCOMP];
	logic signed [RW-1:0] ve_s3 [NCOMP];

	clip_out_t            res_d;
	logic                 valid_s4;
	clip_out_t            res_s4;

	// |end - start| and its sign
	always_comb begin
		logic signed [BW-1:0] d;
		for (int i = 0; i < NCOMP; i++) begin
			d = $signed({in_side.pb[i][CW-1], in_side.pb[i]})
				- $signed({in_side.pa[i][CW-1], in_side.pa[i]});
			neg_d[i] = d[BW-1];
			mag_d[i] = d[BW-1] ? BW'(-d) : BW'(d);
		end
	end

	// rounded offset, end point selection
	always_comb begin
		logic [PW-1:0]        rs, re;
		logic signed [RW-1:0] pa_e, pb_e, os, oe, ls, le;
		for (int i = 0; i < NCOMP; i++) begin
			rs   = prs_s2[i] + T_HALF;
			re   = pre_s2[i] + T_HALF;
			os   = $signed({2'b00, rs[PW-1:TB]});
			oe   = $signed({2'b00, re[PW-1:TB]});
			pa_e = $signed({{(RW-CW){side_s2.pa[i][CW-1]}}, side_s2.pa[i]});
			pb_e = $signed({{(RW-CW){side_s2.pb[i][CW-1]}}, side_s2.pb[i]});
			ls   = sel_s2.tin[TB]  ? pb_e : (neg_s2[i] ? pa_e - os : pa_e + os);
			le   = sel_s2.tout[TB] ? pb_e : (neg_s2[i] ? pa_e - oe : pa_e + oe);
			vs_d[i] = (side_s2.ca != '0) ? ls : pa_e;
			ve_d[i] = (side_s2.cb != '0) ? le : pb_e;
		end
	end

	// saturate; a rejected segment reads as all zero
	always_comb begin
		res_d = '0;
		if (vis_s3) begin
			res_d.visible      = 1'b1;
			res_d.clip_start_x = sat(vs_s3[0]);
			res_d.clip_start_y = sat(vs_s3[1]);
			res_d.clip_start_z = sat(vs_s3[2]);
			res_d.clip_start_w = sat(vs_s3[3]);
			res_d.clip_end_x   = sat(ve_s3[0]);
			res_d.clip_end_y   = sat(ve_s3[1]);
			res_d.clip_end_z   = sat(ve_s3[2]);
			res_d.clip_end_w   = sat(ve_s3[3]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		side_s1 <= in_side;
		sel_s1  <= in_sel;
		mag_s1  <= mag_d;
		neg_s1  <= neg_d;
		side_s2 <= side_s1;
		sel_s2  <= sel_s1;
		neg_s2  <= neg_s1;
		for (int i = 0; i < NCOMP; i++) begin
			prs_s2[i] <= PW'(mag_s1[i]) * PW'(sel_s1.tin[TB-1:0]);
			pre_s2[i] <= PW'(mag_s1[i]) * PW'(sel_s1.tout[TB-1:0]);
		end
		vis_s3  <= sel_s2.visible;
		vs_s3   <= vs_d;
		ve_s3   <= ve_d;
		res_s4  <= res_d;
	end

	assign out_valid  = valid_s4;
	assign out_result = res_s4;

endmodule

`default_nettype wire

// ===== hw/rtl/homogeneous_line_clipper_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// homogeneous_line_clipper_core
// Liang-Barsky clipping of a homogeneous segment against -w <= x,y,z <= w.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive item (both end points, signed Q16.16) and raise start; the
//   transfer happens at the clock edge where start is high and busy is low.
//   busy is always low, so a new segment may enter on every cycle.
//   Output: done pulses for one cycle with result (visible flag and the
//   clipped end points). The receiver cannot hold results off.
// Pipeline from the start transfer to done: 2 setup stages,
//   16 divider stages (2 quotient bits each for the six plane ratios),
//   2 parameter-selection stages and 4 interpolation stages (the 33x32
//   multiply has its own stage).
// Throughput: one segment per cycle; results leave in input order.
// Reset: arst_n clears all valid bits; no done pulse appears until a new
//   segment has passed through the pipeline.
// ----------------------------------------------------------------------------
module homogeneous_line_clipper_core
	import hlc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire clip_in_t item,
	output logic          done,
	output clip_out_t     result
);

	logic  set_valid, div_valid, sel_valid;
	side_t set_side, div_side, sel_side;
	lane_t set_lanes [NPLANE];
	lane_t div_lanes [NPLANE];
	sel_t  sel_res;

	assign busy = 1'b0;

	hlc_setup u_setup (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.in_item   (item),
		.out_valid (set_valid),
		.out_side  (set_side),
		.out_lanes (set_lanes)
	);

	hlc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (set_valid),
		.in_side   (set_side),
		.in_lanes  (set_lanes),
		.out_valid (div_valid),
		.out_side  (div_side),
		.out_lanes (div_lanes)
	);

	hlc_select u_select (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid),
		.in_side   (div_side),
		.in_lanes  (div_lanes),
		.out_valid (sel_valid),
		.out_side  (sel_side),
		.out_sel   (sel_res)
	);

	hlc_interp u_interp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (sel_valid),
		.in_side    (sel_side),
		.in_sel     (sel_res),
		.out_valid  (done),
		.out_result (result)
	);

endmodule

`default_nettype wire

// ===== tb/tb_homogeneous_line_clipper_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_homogeneous_line_clipper_core
// Self-checking bench for the homogeneous line clipper. Segments are queued
// by an initial block and sent by a clocked driver. A golden clip computes
// the expected result of every accepted segment, and a monitor compares
// each done pulse, field by field, against the oldest expected result.
// ----------------------------------------------------------------------------
module tb_homogeneous_line_clipper_core;
	import hlc_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 40;
	localparam logic [63:0] T_UNIT = 64'h1_0000_0000;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	clip_in_t  item;
	logic      done;
	clip_out_t result;

	clip_in_t   pending_segs[$];
	clip_out_t  expected_clips[$];
	int         errors;
	int         idle_cycles;
	int         sender_idle_pct;
	bit         sender_hold;
	bit         stim_done;

	homogeneous_line_clipper_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// saturate to the coordinate range
	function automatic logic [CW-1:0] clamp_coord(input longint v);
		if (v > 64'sd2147483647) return 32'h7fff_ffff;
		if (v < -64'sd2147483648) return 32'h8000_0000;
		return v[CW-1:0];
	endfunction

	// floor(num * 2^32 / den) as a 1.32 fraction, saturated at 1.0
	function automatic logic [63:0] crossing_t(input logic [63:0] num,
			input logic [63:0] den);
		logic [63:0] r;
		logic [63:0] q;
		if (den == 0 || num >= den) return T_UNIT;
		r = num;
		q = 0;
		for (int i = 0; i < 32; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	// move from a toward b by t, offset rounded half away from zero
	function automatic longint move_point(input longint a, input longint b,
			input logic [63:0] t);
		longint      d;
		logic [63:0] mag;
		logic [63:0] off;
		if (t >= T_UNIT) return b;
		d = b - a;
		mag = d < 0 ? -d : d;
		off = (mag >> 32) * t + (((mag & 64'hffff_ffff) * t + 64'h8000_0000) >> 32);
		return d < 0 ? a - longint'(off) : a + longint'(off);
	endfunction

	// golden clip of one segment
	function automatic clip_out_t clip_segment(input clip_in_t s);
		clip_out_t   o;
		longint      pa[4];
		longint      pb[4];
		longint      ba[6];
		longint      bb[6];
		logic [5:0]  ca;
		logic [5:0]  cb;
		logic [63:0] tin;
		logic [63:0] tout;
		logic [63:0] t;
		longint      ps;
		longint      pe;
		o = '0;
		pa = '{longint'(s.start_x), longint'(s.start_y), longint'(s.start_z),
			longint'(s.start_w)};
		pb = '{longint'(s.end_x), longint'(s.end_y), longint'(s.end_z),
			longint'(s.end_w)};
		ca = '0;
		cb = '0;
		for (int i = 0; i < 3; i++) begin
			ba[2*i]   = pa[3] + pa[i];
			ba[2*i+1] = pa[3] - pa[i];
			bb[2*i]   = pb[3] + pb[i];
			bb[2*i+1] = pb[3] - pb[i];
		end
		for (int i = 0; i < 6; i++) begin
			ca[i] = ba[i] <= 0;
			cb[i] = bb[i] <= 0;
		end
		if ((ca & cb) != 0) return o;
		if ((ca | cb) == 0) begin
			o.visible = 1'b1;
			{o.clip_start_x, o.clip_start_y, o.clip_start_z, o.clip_start_w} =
				{s.start_x, s.start_y, s.start_z, s.start_w};
			{o.clip_end_x, o.clip_end_y, o.clip_end_z, o.clip_end_w} =
				{s.end_x, s.end_y, s.end_z, s.end_w};
			return o;
		end
		tin = 0;
		tout = T_UNIT;
		for (int i = 0; i < 6; i++) begin
			if (bb[i] < 0) begin
				t = crossing_t(ba[i], ba[i] - bb[i]);
				if (t < tout) tout = t;
			end else if (ba[i] < 0) begin
				t = crossing_t(-ba[i], bb[i] - ba[i]);
				if (t > tin) tin = t;
			end
		end
		if (tin > tout) return o;
		o.visible = 1'b1;
		for (int i = 0; i < 4; i++) begin
			ps = ca != 0 ? move_point(pa[i], pb[i], tin) : pa[i];
			pe = cb != 0 ? move_point(pa[i], pb[i], tout) : pb[i];
			case (i)
				0: begin
					o.clip_start_x = clamp_coord(ps);
					o.clip_end_x   = clamp_coord(pe);
				end
				1: begin
					o.clip_start_y = clamp_coord(ps);
					o.clip_end_y   = clamp_coord(pe);
				end
				2: begin
					o.clip_start_z = clamp_coord(ps);
					o.clip_end_z   = clamp_coord(pe);
				end
				default: begin
					o.clip_start_w = clamp_coord(ps);
					o.clip_end_w   = clamp_coord(pe);
				end
			endcase
		end
		return o;
	endfunction

	// coordinate of mixed magnitude: full range, exactly +-w or within +-w
	function automatic logic [CW-1:0] rand_coord(input int w);
		case ($urandom_range(0, 9))
			0, 1:    return $urandom;
			2:       return $signed(w) * ($urandom_range(0, 1) ? 1 : -1);
			default: return $signed($urandom_range(0, 2 * w)) - $signed(w);
		endcase
	endfunction

	// random segment, mostly straddling the volume
	function automatic clip_in_t rand_segment();
		clip_in_t s;
		int       ws;
		int       we;
		if ($urandom_range(0, 19) == 0) begin
			s = {$urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom};
			return s;
		end
		ws = $urandom_range(0, 9) == 0 ? $signed($urandom) : $urandom_range(1, 32'h7fff_ffff) >> $urandom_range(0, 16);
		we = $urandom_range(0, 9) == 0 ? $signed($urandom) : $urandom_range(1, 32'h7fff_ffff) >> $urandom_range(0, 16);
		s.start_w = ws;
		s.end_w   = we;
		s.start_x = rand_coord(ws < 0 ? -ws : ws) * ($urandom_range(0, 2) == 0 ? 2 : 1);
		s.start_y = rand_coord(ws < 0 ? -ws : ws);
		s.start_z = rand_coord(ws < 0 ? -ws : ws);
		s.end_x   = rand_coord(we < 0 ? -we : we);
		s.end_y   = rand_coord(we < 0 ? -we : we) * ($urandom_range(0, 2) == 0 ? 2 : 1);
		s.end_z   = rand_coord(we < 0 ? -we : we);
		return s;
	endfunction

	// stimulus: directed cases, then three random phases
	initial begin
		errors = 0;
		stim_done = 1'b0;
		sender_hold = 1'b0;
		sender_idle_pct = 30;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		// inside, accepted unchanged
		pending_segs.push_back({32'sh1000, 32'sh0, -32'sh8000, 32'sh10000,
			-32'sh4000, 32'sh2000, 32'sh0, 32'sh10000});
		// both ends beyond +x: rejected
		pending_segs.push_back({32'sh30000, 32'sh0, 32'sh0, 32'sh10000,
			32'sh20000, 32'sh0, 32'sh0, 32'sh10000});
		// crossing both x planes
		pending_segs.push_back({-32'sh30000, 32'sh0, 32'sh0, 32'sh10000,
			32'sh30000, 32'sh0, 32'sh0, 32'sh10000});
		// end exactly on a plane, other end inside
		pending_segs.push_back({32'sh10000, 32'sh0, 32'sh0, 32'sh10000,
			32'sh0, 32'sh0, 32'sh0, 32'sh10000});
		// entry after exit: rejected across a corner
		pending_segs.push_back({32'sh30000, 32'sh0, 32'sh0, 32'sh10000,
			32'sh0, 32'sh30000, 32'sh0, 32'sh10000});
		// zero and negative w
		pending_segs.push_back({32'sh0, 32'sh0, 32'sh0, 32'sh0,
			32'sh0, 32'sh0, 32'sh0, 32'sh10000});
		pending_segs.push_back({32'sh0, 32'sh0, 32'sh0, -32'sh10000,
			32'sh0, 32'sh0, 32'sh0, 32'sh10000});
		// field extremes, saturating interpolation
		pending_segs.push_back({32'h8000_0000, 32'h0, 32'h0, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h0, 32'h0, 32'h7fff_ffff});
		pending_segs.push_back({32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
			32'h7fff_ffff});
		pending_segs.push_back({8{32'h7fff_ffff}});
		pending_segs.push_back({8{32'h8000_0000}});
		pending_segs.push_back({8{32'hffff_ffff}});
		pending_segs.push_back('0);
		pending_segs.push_back({32'h7fff_fff0, 32'h0, 32'h0, 32'h7fff_ffff,
			32'h8000_0010, 32'h0, 32'h0, 32'h7fff_ffff});
		for (int i = 0; i < 560; i++) pending_segs.push_back(rand_segment());
		wait (pending_segs.size() == 0);
		// hold off until the pipeline has drained
		sender_hold = 1'b1;
		// let the last transfer land in the expected queue
		repeat (2) @(negedge clk);
		wait (expected_clips.size() == 0);
		sender_hold = 1'b0;
		sender_idle_pct = 64;
		for (int i = 0; i < 560; i++) pending_segs.push_back(rand_segment());
		wait (pending_segs.size() == 0);
		sender_idle_pct = 0;
		for (int i = 0; i < 570; i++) pending_segs.push_back(rand_segment());
		wait (pending_segs.size() == 0 && !start);
		stim_done = 1'b1;
	end

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_clips.push_back(clip_segment(item));
			end
			if (start && busy) begin
				start <= 1'b1;
			end else if (pending_segs.size() != 0 && !sender_hold &&
					$urandom_range(0, 99) >= sender_idle_pct) begin
				item  <= pending_segs.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		clip_out_t e;
		if (arst_n && done) begin
			if (expected_clips.size() == 0) begin
				$display("%0t: unexpected result %h", $time, result);
				errors++;
			end else begin
				e = expected_clips.pop_front();
				if (e.visible !== result.visible) begin
					$display("%0t: visible exp %b got %b", $time, e.visible, result.visible);
					errors++;
				end
				if (e.clip_start_x !== result.clip_start_x) begin
					$display("%0t: clip_start_x exp %h got %h", $time, e.clip_start_x,
						result.clip_start_x);
					errors++;
				end
				if (e.clip_start_y !== result.clip_start_y) begin
					$display("%0t: clip_start_y exp %h got %h", $time, e.clip_start_y,
						result.clip_start_y);
					errors++;
				end
				if (e.clip_start_z !== result.clip_start_z) begin
					$display("%0t: clip_start_z exp %h got %h", $time, e.clip_start_z,
						result.clip_start_z);
					errors++;
				end
				if (e.clip_start_w !== result.clip_start_w) begin
					$display("%0t: clip_start_w exp %h got %h", $time, e.clip_start_w,
						result.clip_start_w);
					errors++;
				end
				if (e.clip_end_x !== result.clip_end_x) begin
					$display("%0t: clip_end_x exp %h got %h", $time, e.clip_end_x,
						result.clip_end_x);
					errors++;
				end
				if (e.clip_end_y !== result.clip_end_y) begin
					$display("%0t: clip_end_y exp %h got %h", $time, e.clip_end_y,
						result.clip_end_y);
					errors++;
				end
				if (e.clip_end_z !== result.clip_end_z) begin
					$display("%0t: clip_end_z exp %h got %h", $time, e.clip_end_z,
						result.clip_end_z);
					errors++;
				end
				if (e.clip_end_w !== result.clip_end_w) begin
					$display("%0t: clip_end_w exp %h got %h", $time, e.clip_end_w,
						result.clip_end_w);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no transfer
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((start && !busy) || done) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// end of run
	initial begin
		wait (stim_done);
		wait (expected_clips.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && expected_clips.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/hlc_pkg.sv
hw/rtl/hlc_setup.sv
hw/rtl/hlc_div.sv
hw/rtl/hlc_select.sv
hw/rtl/hlc_interp.sv
hw/rtl/homogeneous_line_clipper_core.sv
tb/tb_homogeneous_line_clipper_core.sv
